// ===== hw/rtl/rmst_pkg.sv =====
// Shared types and constants for the range minimum segment tree.
// No dependencies; used by the top level and its port checker.
package rmst_pkg;

  localparam int VALUE_W = 32;

  // Padding value held by every cell after reset
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // Input transaction kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QWALK,
    ST_QFLUSH
  } state_t;

endpackage

// ===== hw/rtl/range_minimum_segment_tree.sv =====
// Range minimum segment tree: top level with the tree memory and its sequencer.
// Depends on rmst_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: a load
//   (in_kind = load) writes in_value at leaf in_position and refreshes the
//   minimum along the path to the root; a query (in_kind = query) asks for
//   the minimum over positions in_range_low..in_range_high inclusive.
//   Result channel (out_valid / out_stall) returns one transaction per query:
//   the minimum, its rightmost position, and out_empty_range when low > high
//   (then the minimum reads INT_MAX at position 0). Loads return nothing.
//   One transaction is worked on at a time; in_stall is high while busy.
//   Load: one tree level per cycle through the memory read-modify-write loop
//   (sibling read, parent write). Query: one tree level per cycle on two
//   read ports, then a two-stage compare, then the result register; after
//   that the block returns to idle and takes the next transaction.
//   After reset a clearing pass writes all 2*LEAF_COUNT cells, one per
//   cycle; in_stall stays high meanwhile.
//   A finished result waits in the output register while out_stall is high;
//   the next transaction is still taken, and a later query result waits
//   until the register is free.
module range_minimum_segment_tree #(
  parameter int LEAF_COUNT = 1024,
  localparam int POS_W = $clog2(LEAF_COUNT)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [POS_W-1:0]                      in_position,
  input  logic signed [rmst_pkg::VALUE_W-1:0]   in_value,
  input  logic [POS_W-1:0]                      in_range_low,
  input  logic [POS_W-1:0]                      in_range_high,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rmst_pkg::VALUE_W-1:0]   out_min_value,
  output logic [POS_W-1:0]                      out_min_position,
  output logic                                  out_empty_range
);

  localparam int IDX_W     = POS_W + 1;          // node index 0..2N-1
  localparam int BND_W     = POS_W + 2;          // query bound up to 2N
  localparam int CELL_W    = rmst_pkg::VALUE_W + POS_W;
  localparam int MEM_DEPTH = 2 * LEAF_COUNT;

  // Position of the rightmost leaf under a node (leaf: its own position)
  function automatic logic [POS_W-1:0] rightmost_leaf(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] ext;
    logic [POS_W-1:0] res;
    ext = '0;
    res = '0;
    for (int k = 0; k <= POS_W; k++) begin
      if ((idx >> (POS_W - k)) == IDX_W'(1)) begin
        ext = (idx << k) | ((IDX_W'(1) << k) - IDX_W'(1));
        res = ext[POS_W-1:0];
      end
    end
    return res;
  endfunction

  // Candidate (cv, cp) beats best (bv, bp): smaller value, rightmost on ties
  function automatic logic beats(input logic signed [rmst_pkg::VALUE_W-1:0] cv,
                                 input logic [POS_W-1:0] cp,
                                 input logic signed [rmst_pkg::VALUE_W-1:0] bv,
                                 input logic [POS_W-1:0] bp);
    return (cv < bv) || ((cv == bv) && (cp > bp));
  endfunction

  // Tree memory: {value, position} per node
  logic [CELL_W-1:0] mem [MEM_DEPTH];
  logic [CELL_W-1:0] rd_a_data_r, rd_b_data_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_a_en, rd_b_en;
  logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;

  // Sequencer state
  rmst_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Load path walk
  logic [IDX_W-1:0]                    node_r, node_nxt;
  logic signed [rmst_pkg::VALUE_W-1:0] cur_val_r, cur_val_nxt;
  logic [POS_W-1:0]                    cur_pos_r, cur_pos_nxt;

  // Query walk
  logic [BND_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [BND_W-1:0] hi_dec;
  logic             empty_r, empty_nxt;
  logic             qa_vld_r, qa_vld_nxt, qb_vld_r, qb_vld_nxt;

  // Compare stages
  logic                                cand_vld_r, cand_vld_nxt;
  logic signed [rmst_pkg::VALUE_W-1:0] cand_val_r, cand_val_nxt;
  logic [POS_W-1:0]                    cand_pos_r, cand_pos_nxt;
  logic                                best_vld_r, best_vld_nxt;
  logic signed [rmst_pkg::VALUE_W-1:0] best_val_r, best_val_nxt;
  logic [POS_W-1:0]                    best_pos_r, best_pos_nxt;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [rmst_pkg::VALUE_W-1:0] out_val_r, out_val_nxt;
  logic [POS_W-1:0]                    out_pos_r, out_pos_nxt;
  logic                                out_empty_r, out_empty_nxt;

  // Unpacked read data
  logic signed [rmst_pkg::VALUE_W-1:0] a_val, b_val, sib_val;
  logic [POS_W-1:0]                    a_pos, b_pos, sib_pos;
  logic signed [rmst_pkg::VALUE_W-1:0] left_val, right_val, par_val;
  logic [POS_W-1:0]                    left_pos, right_pos, par_pos;
  logic [IDX_W-1:0]                    parent;
  logic                                out_free;

  assign a_val   = rd_a_data_r[CELL_W-1:POS_W];
  assign a_pos   = rd_a_data_r[POS_W-1:0];
  assign b_val   = rd_b_data_r[CELL_W-1:POS_W];
  assign b_pos   = rd_b_data_r[POS_W-1:0];
  assign sib_val = a_val;
  assign sib_pos = a_pos;
  assign parent  = node_r >> 1;
  assign hi_dec  = hi_r - BND_W'(1);

  // Parent of the current load node from the current cell and its sibling
  always_comb begin
    if (node_r[0]) begin
      right_val = cur_val_r;
      right_pos = cur_pos_r;
      left_val  = sib_val;
      left_pos  = sib_pos;
    end else begin
      left_val  = cur_val_r;
      left_pos  = cur_pos_r;
      right_val = sib_val;
      right_pos = sib_pos;
    end
    if (beats(right_val, right_pos, left_val, left_pos)) begin
      par_val = right_val;
      par_pos = right_pos;
    end else begin
      par_val = left_val;
      par_pos = left_pos;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != rmst_pkg::ST_IDLE);

  // Next state, memory control and walk registers. Reads and writes never
  // hit the same cell in one cycle: a load reads the sibling of the node it
  // writes, and transactions do not overlap.
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    node_nxt     = node_r;
    cur_val_nxt  = cur_val_r;
    cur_pos_nxt  = cur_pos_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    empty_nxt    = empty_r;
    best_vld_nxt = best_vld_r;
    best_val_nxt = best_val_r;
    best_pos_nxt = best_pos_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_a_en      = 1'b0;
    rd_a_addr    = '0;
    rd_b_en      = 1'b0;
    rd_b_addr    = '0;
    qa_vld_nxt   = 1'b0;
    qb_vld_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_pos_nxt   = out_pos_r;
    out_empty_nxt = out_empty_r;

    // Stage 2: fold the registered candidate into the running best
    if (cand_vld_r && (!best_vld_r || beats(cand_val_r, cand_pos_r, best_val_r, best_pos_r)))
    begin
      best_vld_nxt = 1'b1;
      best_val_nxt = cand_val_r;
      best_pos_nxt = cand_pos_r;
    end

    unique case (state_r)
      rmst_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = {rmst_pkg::INT_MAX, rightmost_leaf(clr_cnt_r)};
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == rmst_pkg::KIND_LOAD) begin
            // Write the leaf and fetch its sibling
            wr_en       = 1'b1;
            wr_addr     = {1'b1, in_position};
            wr_data     = {in_value, in_position};
            rd_a_en     = 1'b1;
            rd_a_addr   = {1'b1, in_position} ^ IDX_W'(1);
            node_nxt    = {1'b1, in_position};
            cur_val_nxt = in_value;
            cur_pos_nxt = in_position;
            state_nxt   = rmst_pkg::ST_LOAD;
          end else begin
            lo_nxt       = {2'b01, in_range_low};
            hi_nxt       = {2'b01, in_range_high} + BND_W'(1);
            empty_nxt    = in_range_low > in_range_high;
            best_vld_nxt = 1'b0;
            state_nxt    = rmst_pkg::ST_QWALK;
          end
        end
      end
      rmst_pkg::ST_LOAD: begin
        // One level per cycle: write parent, fetch the parent's sibling unless the parent is the root
        wr_en       = 1'b1;
        wr_addr     = parent;
        wr_data     = {par_val, par_pos};
        node_nxt    = parent;
        cur_val_nxt = par_val;
        cur_pos_nxt = par_pos;
        if (parent == IDX_W'(1)) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = parent ^ IDX_W'(1);
        end
      end
      rmst_pkg::ST_QWALK: begin
        if (!empty_r && (lo_r < hi_r)) begin
          rd_a_en    = lo_r[0];
          rd_a_addr  = lo_r[IDX_W-1:0];
          rd_b_en    = hi_r[0];
          rd_b_addr  = hi_dec[IDX_W-1:0];
          qa_vld_nxt = lo_r[0];
          qb_vld_nxt = hi_r[0];
          lo_nxt     = (lo_r + BND_W'(lo_r[0])) >> 1;
          hi_nxt     = (hi_r - BND_W'(hi_r[0])) >> 1;
        end else begin
          state_nxt = rmst_pkg::ST_QFLUSH;
        end
      end
      rmst_pkg::ST_QFLUSH: begin
        // Wait for the compare stages to drain and the output register to be free, then post the result
        if (!qa_vld_r && !qb_vld_r && !cand_vld_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = empty_r;
          if (empty_r) begin
            out_val_nxt = rmst_pkg::INT_MAX;
            out_pos_nxt = '0;
          end else begin
            out_val_nxt = best_val_r;
            out_pos_nxt = best_pos_r;
          end
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  // Stage 1: better of the two cells read in the previous cycle
  always_comb begin
    cand_vld_nxt = qa_vld_r || qb_vld_r;
    if (qa_vld_r && (!qb_vld_r || !beats(b_val, b_pos, a_val, a_pos))) begin
      cand_val_nxt = a_val;
      cand_pos_nxt = a_pos;
    end else begin
      cand_val_nxt = b_val;
      cand_pos_nxt = b_pos;
    end
  end

  // Tree memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data_r <= mem[rd_b_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmst_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      qa_vld_r    <= 1'b0;
      qb_vld_r    <= 1'b0;
      cand_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      qa_vld_r    <= qa_vld_nxt;
      qb_vld_r    <= qb_vld_nxt;
      cand_vld_r  <= cand_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    cur_val_r   <= cur_val_nxt;
    cur_pos_r   <= cur_pos_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    empty_r     <= empty_nxt;
    cand_val_r  <= cand_val_nxt;
    cand_pos_r  <= cand_pos_nxt;
    best_val_r  <= best_val_nxt;
    best_pos_r  <= best_pos_nxt;
    out_val_r   <= out_val_nxt;
    out_pos_r   <= out_pos_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_value    = out_val_r;
  assign out_min_position = out_pos_r;
  assign out_empty_range  = out_empty_r;

endmodule

// ===== hw/rtl/rmst_checker.sv =====
// Port-level assertions for the range minimum segment tree, and their bind.
// Depends on rmst_pkg; attaches to range_minimum_segment_tree.
module rmst_checker #(
  parameter int POS_W = 10
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_kind,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [rmst_pkg::VALUE_W-1:0] out_min_value,
  input logic [POS_W-1:0]                    out_min_position,
  input logic                                out_empty_range
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_value)
      && $stable(out_min_position) && $stable(out_empty_range))
    else $error("stalled result changed");

  // An empty range reports padding at position zero
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_range |-> out_min_value == rmst_pkg::INT_MAX
      && out_min_position == '0)
    else $error("empty range result not padding");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A load keeps the block busy while it walks the tree
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == rmst_pkg::KIND_LOAD |=> in_stall)
    else $error("new transaction taken during load walk");

endmodule

bind range_minimum_segment_tree rmst_checker #(.POS_W(POS_W)) u_rmst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_min_value    (out_min_value),
  .out_min_position (out_min_position),
  .out_empty_range  (out_empty_range)
);
